// ===== design/lmrs_pkg.sv =====
package lmrs_pkg;

   // Panel geometry.
   localparam int ROW_PIXELS = 64;
   localparam int SCAN_ROWS  = 16;
   localparam int STORE_SIZE = ROW_PIXELS * SCAN_ROWS;

   // Field widths fixed by the interface.
   localparam int PIX_ADDR_W = 10;
   localparam int ROW_W      = 4;
   localparam int SCROLL_W   = 10;
   localparam int TICKS_W    = 8;
   localparam int CSR_DATA_W = 10;
   localparam int CSR_IDX_W  = 1;

   // Derived widths.
   localparam int SADDR_W = $clog2(STORE_SIZE);
   localparam int COL_W   = $clog2(ROW_PIXELS);
   localparam int WORK_W  = ((SADDR_W > PIX_ADDR_W) ? SADDR_W : PIX_ADDR_W) + 1;

   // Reset values of the registers.
   localparam logic [SCROLL_W-1:0] SCROLL_RESET = '0;
   localparam logic [TICKS_W-1:0]  TICKS_RESET  = TICKS_W'(10);

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_SCROLL_OFFSET = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ON_TICKS      = 1'b1;

   // Operation codes.
   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_REDUCE,
      ST_SHIFT,
      ST_TICK
   } state_type;

   // Write port of the frame store.
   typedef struct packed {
      logic               en;
      logic [SADDR_W-1:0] addr;
      logic               data;
   } store_wr_type;

   // Read port of the frame store.
   typedef struct packed {
      logic               en;
      logic [SADDR_W-1:0] addr;
   } store_rd_type;

endpackage

// ===== design/led_matrix_row_scanner_core.sv =====
// Row scan driver for a one-in-sixteen multiplexed single-color LED panel.
// The req_ channel carries pixel writes (operation 1) and timer ticks
// (operation 0). A write stores one bit in the frame store and returns
// nothing. A tick at phase 0 shifts out one row: ROW_PIXELS results, one
// per cycle while the result register can take them, with the latch and
// new row on the final one. Any other tick returns a single result.
// Ticks are handled one at a time; the shift rate of one bit per cycle is
// set by the single read port of the frame store. The store read address is
// reduced modulo the store size by one shared compare-and-subtract unit.
// The csr_ port writes scroll_offset (index 0) and on_ticks (index 1) and
// is taken at any cycle with csr_write_enable high.
// After reset the frame store is cleared one entry per cycle, with
// req_stall held high. When rsp_stall is high while a result is held, the
// result register holds and the shift sequence pauses; nothing is dropped.
module led_matrix_row_scanner_core
   import lmrs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_operation,
   input  logic [PIX_ADDR_W-1:0] req_pixel_address,
   input  logic                  req_pixel_value,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_serial_bit,
   output logic                  rsp_shift_pulse,
   output logic [ROW_W-1:0]      rsp_row_select,
   output logic                  rsp_enable_level,
   output logic                  rsp_latch_pulse,
   output logic                  rsp_last,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   state_type state_ff, state_in;

   logic [SCROLL_W-1:0] scroll_ff, scroll_in;
   logic [TICKS_W-1:0]  on_ticks_ff, on_ticks_in;
   logic [TICKS_W-1:0]  phase_ff, phase_in;
   logic [ROW_W-1:0]    scan_row_ff, scan_row_in;
   logic [ROW_W-1:0]    driven_row_ff, driven_row_in;
   logic                enable_ff, enable_in;

   logic [SADDR_W-1:0]  clear_ff, clear_in;
   logic [WORK_W-1:0]   work_ff, work_in;
   logic                is_write_ff, is_write_in;
   logic                wr_value_ff, wr_value_in;
   logic [SADDR_W-1:0]  rd_addr_ff, rd_addr_in;
   logic [COL_W-1:0]    col_ff, col_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                shift_ff, shift_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic                en_ff, en_in;
   logic                latch_ff, latch_in;
   logic                last_ff, last_in;

   store_wr_type store_wr;
   store_rd_type store_rd;
   logic         store_data;
   logic         slot_free;
   logic         req_transfer;

   lmrs_frame_store u_store (
      .clock   (clock),
      .wr      (store_wr),
      .rd      (store_rd),
      .rd_data (store_data)
   );

   assign slot_free    = !rsp_valid_ff || !rsp_stall;
   assign req_stall    = (state_ff != ST_IDLE);
   assign req_transfer = req_valid && (state_ff == ST_IDLE);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         scroll_ff     <= SCROLL_RESET;
         on_ticks_ff   <= TICKS_RESET;
         phase_ff      <= '0;
         scan_row_ff   <= '0;
         driven_row_ff <= '0;
         enable_ff     <= 1'b1;
         clear_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         scroll_ff     <= scroll_in;
         on_ticks_ff   <= on_ticks_in;
         phase_ff      <= phase_in;
         scan_row_ff   <= scan_row_in;
         driven_row_ff <= driven_row_in;
         enable_ff     <= enable_in;
         clear_ff      <= clear_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Working and result payload registers.
   always_ff @(posedge clock) begin
      work_ff     <= work_in;
      is_write_ff <= is_write_in;
      wr_value_ff <= wr_value_in;
      rd_addr_ff  <= rd_addr_in;
      col_ff      <= col_in;
      shift_ff    <= shift_in;
      row_ff      <= row_in;
      en_ff       <= en_in;
      latch_ff    <= latch_in;
      last_ff     <= last_in;
   end

   // Sequencer: next state and datapath controls.
   always_comb begin
      state_in      = state_ff;
      scroll_in     = scroll_ff;
      on_ticks_in   = on_ticks_ff;
      phase_in      = phase_ff;
      scan_row_in   = scan_row_ff;
      driven_row_in = driven_row_ff;
      enable_in     = enable_ff;
      clear_in      = clear_ff;
      work_in       = work_ff;
      is_write_in   = is_write_ff;
      wr_value_in   = wr_value_ff;
      rd_addr_in    = rd_addr_ff;
      col_in        = col_ff;
      shift_in      = shift_ff;
      row_in        = row_ff;
      en_in         = en_ff;
      latch_in      = latch_ff;
      last_in       = last_ff;
      store_wr      = '{en: 1'b0, addr: clear_ff, data: 1'b0};
      store_rd      = '{en: 1'b0, addr: rd_addr_ff};

      // The result register empties once its transfer completes.
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      // Register writes.
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SCROLL_OFFSET: scroll_in = SCROLL_W'(csr_write_data);
            CSR_ON_TICKS:      on_ticks_in = TICKS_W'(csr_write_data);
         endcase
      end

      unique case (state_ff)
         // Zero the frame store after reset, one entry per cycle.
         ST_CLEAR: begin
            store_wr = '{en: 1'b1, addr: clear_ff, data: 1'b0};
            clear_in = clear_ff + 1'b1;
            if (clear_ff == SADDR_W'(STORE_SIZE - 1)) begin
               state_in = ST_IDLE;
            end
         end

         // Take the next item.
         ST_IDLE: begin
            if (req_transfer) begin
               if (req_operation == OP_WRITE) begin
                  work_in     = WORK_W'(req_pixel_address);
                  is_write_in = 1'b1;
                  wr_value_in = req_pixel_value;
                  state_in    = ST_REDUCE;
               end else if (phase_ff == '0) begin
                  work_in = WORK_W'(scan_row_ff) * WORK_W'(ROW_PIXELS)
                          + WORK_W'(scroll_ff);
                  is_write_in = 1'b0;
                  state_in    = ST_REDUCE;
               end else begin
                  // Timing tick: blank and advance, or just count.
                  if (phase_ff == on_ticks_ff) begin
                     enable_in = 1'b1;
                     phase_in  = '0;
                     if (scan_row_ff >= ROW_W'(SCAN_ROWS - 1)) begin
                        scan_row_in = '0;
                     end else begin
                        scan_row_in = scan_row_ff + 1'b1;
                     end
                  end else begin
                     phase_in = phase_ff + 1'b1;
                  end
                  state_in = ST_TICK;
               end
            end
         end

         // Shared compare-and-subtract: bring the address below the store size.
         ST_REDUCE: begin
            if (work_ff >= WORK_W'(STORE_SIZE)) begin
               work_in = work_ff - WORK_W'(STORE_SIZE);
            end else if (is_write_ff) begin
               store_wr = '{en: 1'b1, addr: work_ff[SADDR_W-1:0], data: wr_value_ff};
               state_in = ST_IDLE;
            end else begin
               rd_addr_in = work_ff[SADDR_W-1:0];
               col_in     = '0;
               state_in   = ST_SHIFT;
            end
         end

         // Shift one bit per cycle while the result register can take it.
         ST_SHIFT: begin
            if (slot_free) begin
               store_rd     = '{en: 1'b1, addr: rd_addr_ff};
               rsp_valid_in = 1'b1;
               shift_in     = 1'b1;
               if (rd_addr_ff == SADDR_W'(STORE_SIZE - 1)) begin
                  rd_addr_in = '0;
               end else begin
                  rd_addr_in = rd_addr_ff + 1'b1;
               end
               if (col_ff == COL_W'(ROW_PIXELS - 1)) begin
                  // Final bit: drive the new row, unblank and latch.
                  driven_row_in = scan_row_ff;
                  enable_in     = 1'b0;
                  phase_in      = TICKS_W'(1);
                  row_in        = scan_row_ff;
                  en_in         = 1'b0;
                  latch_in      = 1'b1;
                  last_in       = 1'b1;
                  state_in      = ST_IDLE;
               end else begin
                  col_in   = col_ff + 1'b1;
                  row_in   = driven_row_ff;
                  en_in    = enable_ff;
                  latch_in = 1'b0;
                  last_in  = 1'b0;
               end
            end
         end

         // Single status result of a timing tick.
         ST_TICK: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               shift_in     = 1'b0;
               row_in       = driven_row_ff;
               en_in        = enable_ff;
               latch_in     = 1'b0;
               last_in      = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result channel.
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_serial_bit   = shift_ff & store_data;
   assign rsp_shift_pulse  = shift_ff;
   assign rsp_row_select   = row_ff;
   assign rsp_enable_level = en_ff;
   assign rsp_latch_pulse  = latch_ff;
   assign rsp_last         = last_ff;

endmodule

// ===== design/lmrs_frame_store.sv =====
module lmrs_frame_store
   import lmrs_pkg::*;
(
   input  logic         clock,
   input  store_wr_type wr,
   input  store_rd_type rd,
   output logic         rd_data
);

   logic mem [STORE_SIZE];
   logic rd_data_ff;

   // Single write port.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // Registered read; the data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
